@@ sv/irc_atm_pkg.sv @@
// Shared types and constants for the IRC auto-trim machine.
package irc_atm_pkg;

  localparam int unsigned BusHzW   = 27;
  localparam int unsigned CoreHzW  = 28;
  localparam int unsigned CmpW     = 16;
  localparam int unsigned CyclesW  = 32;
  localparam int unsigned HzW      = 23;
  localparam int unsigned LeftW    = 20;
  localparam int unsigned ProdW    = CyclesW + BusHzW;
  localparam int unsigned DvdW     = ProdW + 1;
  localparam int unsigned RemW     = CoreHzW + 1;
  localparam int unsigned CntW     = 6;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 28;

  localparam logic [CoreHzW-1:0] SlowFactor = CoreHzW'(21);
  localparam logic [CoreHzW-1:0] FastFactor = CoreHzW'(21 * 128);

  localparam logic [BusHzW-1:0] FastMinHz = BusHzW'(3000000);
  localparam logic [BusHzW-1:0] FastMaxHz = BusHzW'(5000000);
  localparam logic [BusHzW-1:0] SlowMinHz = BusHzW'(31250);
  localparam logic [BusHzW-1:0] SlowMaxHz = BusHzW'(39063);
  localparam logic [BusHzW-1:0] BusMinHz  = BusHzW'(8000000);
  localparam logic [BusHzW-1:0] BusMaxHz  = BusHzW'(16000000);
  localparam logic [BusHzW-1:0] HzMax     = BusHzW'(23'h7FFFFF);

  localparam logic [CntW-1:0] RatioSteps  = CntW'(CmpW);
  localparam logic [CntW-1:0] TargetSteps = CntW'(BusHzW);
  localparam logic [CntW-1:0] AdvSteps    = CntW'(DvdW);

  localparam logic [1:0] SrcModeInvalid = 2'd1;

  typedef enum logic [1:0] {
    REQ_START   = 2'd0,
    REQ_ADVANCE = 2'd1,
    REQ_ABORT   = 2'd2,
    REQ_NONE    = 2'd3
  } req_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_BUS_HZ    = 3'd0,
    CFG_CORE_HZ   = 3'd1,
    CFG_COMPARE   = 3'd2,
    CFG_FAST_SEL  = 3'd3,
    CFG_INT_REF   = 3'd4,
    CFG_SRC_MODE  = 3'd5,
    CFG_EXT_REF   = 3'd6,
    CFG_UNUSED    = 3'd7
  } cfg_idx_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_LOAD,
    S_RATIO,
    S_TARGET,
    S_ADV,
    S_FIN
  } state_e;

endpackage

@@ sv/irc_auto_trim_machine_unit.sv @@
// IRC auto-trim machine: sequencer around one shared restoring divider.
//
//  channel | signals                                   | direction
//  --------+-------------------------------------------+----------
//  cfg     | cfg_valid_i/cfg_ready_o, cfg_index_i, data | in
//  in      | in_valid_i/in_ready_o, req_type_i, cycles  | in
//  out     | out_valid_o/out_ready_i, status and trim   | out
//
// One item at a time; in_ready_o is high only while the sequencer is idle.
// Start: a 16-step ratio divide, then a 27-step target divide unless the ratio is zero.
// Advance while running: multiply, then a 60-step divide by core_hz (none with a stopped
// clock); other items skip the divider. The divider retires one quotient bit per cycle.
// A result waits in the output register; the sequencer holds until it is taken.
// Reset initialises state, configuration and handshake registers at once, no sweep.
module irc_auto_trim_machine_unit
  import irc_atm_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [1:0]          req_type_i,
  input  logic [CyclesW-1:0]  core_cycles_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic                busy_res_o,
  output logic                failed_o,
  output logic                finished_o,
  output logic                trim_applied_o,
  output logic                trimmed_fast_o,
  output logic [HzW-1:0]      trimmed_hz_o
);

  // configuration
  logic [BusHzW-1:0]  bus_hz_q;
  logic [CoreHzW-1:0] core_hz_q;
  logic [CmpW-1:0]    cmp_q;
  logic               fast_sel_q, int_ref_q, ext_ref_q;
  logic [1:0]         src_mode_q;

  // machine state
  state_e             state_q, state_d;
  logic               running_q, running_d;
  logic               fail_q, fail_d;
  logic [LeftW-1:0]   left_q, left_d;
  logic [CoreHzW-1:0] tick_q, tick_d;
  logic [HzW-1:0]     target_q, target_d;
  logic               tvalid_q, tvalid_d;

  // divider and scratch
  logic [DvdW-1:0]    dq_q, dq_d;
  logic [RemW-1:0]    rem_q, rem_d;
  logic [CoreHzW-1:0] dvs_q, dvs_d;
  logic [CntW-1:0]    cnt_q, cnt_d;
  logic [ProdW-1:0]   prod_q, prod_d;
  logic               modz_q, modz_d;
  logic               fin_q, fin_d, appl_q, appl_d, tfast_q, tfast_d;
  logic [HzW-1:0]     thz_q, thz_d;

  // output register
  logic               out_valid_q, out_valid_d;
  logic               out_load;

  logic               in_fire, clk_ok, cfg_ok, div_busy;
  logic [RemW-1:0]    shifted, rem_step;
  logic               ge;
  logic [CmpW-1:0]    ratio;
  logic [CmpW-1:0]    cmp_eff;
  logic [LeftW-1:0]   left_load;
  logic [BusHzW-1:0]  tgt_c, lo_c, hi_c;
  logic               start_commit, valid_c;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = (state_q == S_IDLE);
  assign in_fire     = in_valid_i && in_ready_o;
  assign out_load    = (state_q == S_FIN) && (!out_valid_q || out_ready_i);
  assign out_valid_o = out_valid_q;

  assign clk_ok   = (bus_hz_q != '0) && (core_hz_q != '0);
  assign cfg_ok   = (bus_hz_q >= BusMinHz) && (bus_hz_q <= BusMaxHz) && !int_ref_q &&
                    (src_mode_q != SrcModeInvalid) && ext_ref_q;
  assign div_busy = (cnt_q != '0);

  // shared divider step
  assign shifted  = {rem_q[RemW-2:0], dq_q[DvdW-1]};
  assign ge       = shifted >= {1'b0, dvs_q};
  assign rem_step = ge ? shifted - {1'b0, dvs_q} : shifted;

  assign ratio     = dq_q[CmpW-1:0];
  assign cmp_eff   = (cmp_q == '0) ? CmpW'(1) : cmp_q;
  assign left_load = fast_sel_q ? {2'b0, cmp_eff, 2'b0}
                                : {1'b0, cmp_eff, 3'b0} + {4'b0, cmp_eff};
  assign tgt_c     = (state_q == S_TARGET) ? dq_q[BusHzW-1:0] : '0;
  assign lo_c      = fast_sel_q ? FastMinHz : SlowMinHz;
  assign hi_c      = fast_sel_q ? FastMaxHz : SlowMaxHz;
  assign valid_c   = cfg_ok && (state_q == S_TARGET) && modz_q &&
                     (tgt_c >= lo_c) && (tgt_c <= hi_c);
  assign start_commit = !div_busy &&
                        ((state_q == S_TARGET) || ((state_q == S_RATIO) && ratio == '0));

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          if (req_e'(req_type_i) == REQ_START) begin
            state_d = S_RATIO;
          end else if (req_e'(req_type_i) == REQ_ADVANCE && running_q) begin
            state_d = clk_ok ? S_LOAD : S_ADV;
          end else begin
            state_d = S_FIN;
          end
        end
      end
      S_LOAD: state_d = S_ADV;
      S_RATIO: begin
        if (!div_busy) begin
          state_d = (ratio == '0) ? S_FIN : S_TARGET;
        end
      end
      S_TARGET, S_ADV: begin
        if (!div_busy) begin
          state_d = S_FIN;
        end
      end
      S_FIN: begin
        if (out_load) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // datapath and machine updates
  always_comb begin
    running_d   = running_q;
    fail_d      = fail_q;
    left_d      = left_q;
    tick_d      = tick_q;
    target_d    = target_q;
    tvalid_d    = tvalid_q;
    dq_d        = dq_q;
    rem_d       = rem_q;
    dvs_d       = dvs_q;
    cnt_d       = cnt_q;
    prod_d      = prod_q;
    modz_d      = modz_q;
    fin_d       = fin_q;
    appl_d      = appl_q;
    tfast_d     = tfast_q;
    thz_d       = thz_q;
    out_valid_d = out_valid_q && !out_ready_i;

    unique case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          fin_d   = 1'b0;
          appl_d  = 1'b0;
          tfast_d = 1'b0;
          thz_d   = '0;
          prod_d  = ProdW'(core_cycles_i) * ProdW'(bus_hz_q);
          case (req_e'(req_type_i))
            REQ_START: begin
              dq_d  = {cmp_q, {(DvdW-CmpW){1'b0}}};
              rem_d = '0;
              dvs_d = fast_sel_q ? FastFactor : SlowFactor;
              cnt_d = RatioSteps;
            end
            REQ_ADVANCE: begin
              dq_d  = '0;
              rem_d = {1'b0, tick_q};
              cnt_d = '0;
            end
            REQ_ABORT: begin
              if (running_q) begin
                fail_d    = 1'b1;
                running_d = 1'b0;
                left_d    = '0;
                tick_d    = '0;
                target_d  = '0;
                tvalid_d  = 1'b0;
              end
            end
            default: ;
          endcase
        end
      end
      S_LOAD: begin
        dq_d  = {1'b0, prod_q} + DvdW'(tick_q);
        rem_d = '0;
        dvs_d = core_hz_q;
        cnt_d = AdvSteps;
      end
      S_RATIO, S_TARGET, S_ADV: begin
        if (div_busy) begin
          dq_d  = {dq_q[DvdW-2:0], ge};
          rem_d = rem_step;
          cnt_d = cnt_q - CntW'(1);
        end else if (state_q == S_RATIO && ratio != '0) begin
          modz_d = (rem_q == '0);
          dq_d   = {bus_hz_q, {(DvdW-BusHzW){1'b0}}};
          rem_d  = '0;
          dvs_d  = CoreHzW'(ratio);
          cnt_d  = TargetSteps;
        end else if (state_q == S_ADV) begin
          if (dq_q < DvdW'(left_q)) begin
            left_d = left_q - dq_q[LeftW-1:0];
            tick_d = rem_q[CoreHzW-1:0];
          end else begin
            fin_d     = 1'b1;
            appl_d    = tvalid_q;
            tfast_d   = tvalid_q && fast_sel_q;
            thz_d     = tvalid_q ? target_q : '0;
            fail_d    = fail_q || !tvalid_q;
            running_d = 1'b0;
            left_d    = '0;
            tick_d    = '0;
            target_d  = '0;
            tvalid_d  = 1'b0;
          end
        end
        if (start_commit) begin
          tvalid_d  = valid_c;
          target_d  = (tgt_c > HzMax) ? HzMax[HzW-1:0] : tgt_c[HzW-1:0];
          left_d    = left_load;
          tick_d    = '0;
          running_d = 1'b1;
        end
      end
      S_FIN: begin
        if (out_load) begin
          out_valid_d = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      running_q   <= 1'b0;
      fail_q      <= 1'b0;
      left_q      <= '0;
      tick_q      <= '0;
      target_q    <= '0;
      tvalid_q    <= 1'b0;
      out_valid_q <= 1'b0;
      bus_hz_q    <= '0;
      core_hz_q   <= '0;
      cmp_q       <= '0;
      fast_sel_q  <= 1'b0;
      int_ref_q   <= 1'b1;
      src_mode_q  <= '0;
      ext_ref_q   <= 1'b0;
    end else begin
      state_q     <= state_d;
      running_q   <= running_d;
      fail_q      <= fail_d;
      left_q      <= left_d;
      tick_q      <= tick_d;
      target_q    <= target_d;
      tvalid_q    <= tvalid_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i && cfg_ready_o) begin
        unique case (cfg_idx_e'(cfg_index_i))
          CFG_BUS_HZ:   bus_hz_q   <= cfg_data_i[BusHzW-1:0];
          CFG_CORE_HZ:  core_hz_q  <= cfg_data_i[CoreHzW-1:0];
          CFG_COMPARE:  cmp_q      <= cfg_data_i[CmpW-1:0];
          CFG_FAST_SEL: fast_sel_q <= cfg_data_i[0];
          CFG_INT_REF:  int_ref_q  <= cfg_data_i[0];
          CFG_SRC_MODE: src_mode_q <= cfg_data_i[1:0];
          CFG_EXT_REF:  ext_ref_q  <= cfg_data_i[0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    dq_q    <= dq_d;
    rem_q   <= rem_d;
    dvs_q   <= dvs_d;
    cnt_q   <= cnt_d;
    prod_q  <= prod_d;
    modz_q  <= modz_d;
    fin_q   <= fin_d;
    appl_q  <= appl_d;
    tfast_q <= tfast_d;
    thz_q   <= thz_d;
    if (out_load) begin
      busy_res_o     <= running_q;
      failed_o       <= fail_q;
      finished_o     <= fin_q;
      trim_applied_o <= appl_q;
      trimmed_fast_o <= tfast_q;
      trimmed_hz_o   <= thz_q;
    end
  end

  a_fail_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fail_q |=> fail_q) else $error("fail flag dropped");

  a_running_left: assert property (@(posedge clk_i) disable iff (!rst_ni)
    running_q |-> left_q != '0) else $error("running with empty countdown");

  a_rem_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == S_RATIO || state_q == S_TARGET || state_q == S_ADV) && div_busy)
    |-> rem_q < {1'b0, dvs_q}) else $error("divider remainder out of range");

  a_applied_fin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && trim_applied_o) |-> (finished_o && trimmed_hz_o != '0))
    else $error("trim applied without completion");

  a_busy_after_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_TARGET && !div_busy) |=> running_q)
    else $error("start did not set running");

endmodule

@@ verif/irc_trim_checker.sv @@
// Checker for the IRC auto-trim machine: mirrors its registers, predicts each status item, compares.
module irc_trim_checker
  import irc_atm_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_valid_i,
  input  logic                cfg_ready_i,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  input  logic                in_valid_i,
  input  logic                in_ready_i,
  input  logic [1:0]          req_type_i,
  input  logic [CyclesW-1:0]  core_cycles_i,
  input  logic                out_valid_i,
  input  logic                out_ready_i,
  input  logic                busy_res_i,
  input  logic                failed_i,
  input  logic                finished_i,
  input  logic                trim_applied_i,
  input  logic                trimmed_fast_i,
  input  logic [HzW-1:0]      trimmed_hz_i,
  output int unsigned         errors_o,
  output int unsigned         pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned SlowDiv   = 21;
  localparam int unsigned FastDiv   = 21 * 128;
  localparam int unsigned SlowLoHz  = 31_250;
  localparam int unsigned SlowHiHz  = 39_063;
  localparam int unsigned FastLoHz  = 3_000_000;
  localparam int unsigned FastHiHz  = 5_000_000;
  localparam int unsigned BusLoHz   = 8_000_000;
  localparam int unsigned BusHiHz   = 16_000_000;
  localparam int unsigned SlowSteps = 9;
  localparam int unsigned FastSteps = 4;
  localparam logic [HzW-1:0] HzSat  = '1;

  typedef struct packed {
    logic           busy;
    logic           failed;
    logic           finished;
    logic           applied;
    logic           fast;
    logic [HzW-1:0] hz;
  } trim_status_t;

  trim_status_t status_q[$];

  // register mirror
  logic [BusHzW-1:0]  bus_hz;
  logic [CoreHzW-1:0] core_hz;
  logic [CmpW-1:0]    cmp_val;
  logic               fast_sel;
  logic               int_ref;
  logic [1:0]         src_mode;
  logic               ext_ref;

  // trim machine
  logic               running;
  logic               fail_flag;
  logic               tgt_valid;
  logic [LeftW-1:0]   cycles_left;
  logic [CoreHzW-1:0] tick_rem;
  logic [HzW-1:0]     tgt_hz;

  function automatic void clear_trim();
    running     = 1'b0;
    cycles_left = '0;
    tick_rem    = '0;
    tgt_hz      = '0;
    tgt_valid   = 1'b0;
  endfunction

  function automatic void start_trim();
    int unsigned div;
    int unsigned ratio;
    int unsigned tgt;
    int unsigned lo;
    int unsigned hi;
    div   = fast_sel ? FastDiv : SlowDiv;
    lo    = fast_sel ? FastLoHz : SlowLoHz;
    hi    = fast_sel ? FastHiHz : SlowHiHz;
    ratio = cmp_val / div;
    tgt   = (ratio == 0) ? 0 : bus_hz / ratio;
    tgt_valid = bus_hz >= BusLoHz && bus_hz <= BusHiHz && !int_ref &&
                src_mode != SrcModeInvalid && ext_ref && ratio != 0 &&
                (cmp_val % div) == 0 && tgt >= lo && tgt <= hi;
    tgt_hz      = (tgt > HzSat) ? HzSat : HzW'(tgt);
    cycles_left = LeftW'((cmp_val == 0 ? 1 : cmp_val) * (fast_sel ? FastSteps : SlowSteps));
    tick_rem    = '0;
    running     = 1'b1;
  endfunction

  function automatic trim_status_t step_trim(req_e req, logic [CyclesW-1:0] cyc);
    trim_status_t st;
    logic [63:0]  acc;
    logic [63:0]  elapsed;
    st = '0;
    case (req)
      REQ_START: begin
        start_trim();
      end
      REQ_ADVANCE: begin
        if (running) begin
          elapsed = '0;
          if (bus_hz != 0 && core_hz != 0) begin
            acc      = 64'(tick_rem) + 64'(cyc) * 64'(bus_hz);
            tick_rem = CoreHzW'(acc % 64'(core_hz));
            elapsed  = acc / 64'(core_hz);
          end
          if (elapsed < 64'(cycles_left)) begin
            cycles_left -= LeftW'(elapsed);
          end else begin
            st.finished = 1'b1;
            if (tgt_valid) begin
              st.applied = 1'b1;
              st.fast    = fast_sel;
              st.hz      = tgt_hz;
            end else begin
              fail_flag = 1'b1;
            end
            clear_trim();
          end
        end
      end
      REQ_ABORT: begin
        if (running) begin
          fail_flag = 1'b1;
          clear_trim();
        end
      end
      default: ;
    endcase
    st.busy   = running;
    st.failed = fail_flag;
    return st;
  endfunction

  task automatic check_field(string name, longint unsigned want, longint unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      errors_o++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    trim_status_t want;
    if (!rst_ni) begin
      bus_hz    = '0;
      core_hz   = '0;
      cmp_val   = '0;
      fast_sel  = 1'b0;
      int_ref   = 1'b1;
      src_mode  = '0;
      ext_ref   = 1'b0;
      fail_flag = 1'b0;
      clear_trim();
      status_q.delete();
      errors_o  = 0;
      pending_o = 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_idx_e'(cfg_index_i))
          CFG_BUS_HZ:   bus_hz   = cfg_data_i[BusHzW-1:0];
          CFG_CORE_HZ:  core_hz  = cfg_data_i[CoreHzW-1:0];
          CFG_COMPARE:  cmp_val  = cfg_data_i[CmpW-1:0];
          CFG_FAST_SEL: fast_sel = cfg_data_i[0];
          CFG_INT_REF:  int_ref  = cfg_data_i[0];
          CFG_SRC_MODE: src_mode = cfg_data_i[1:0];
          CFG_EXT_REF:  ext_ref  = cfg_data_i[0];
          default: ;
        endcase
      end
      if (out_valid_i && out_ready_i) begin
        if (status_q.size() == 0) begin
          $error("status item with nothing outstanding");
          errors_o++;
        end else begin
          want = status_q.pop_front();
          check_field("busy_res", want.busy, busy_res_i);
          check_field("failed", want.failed, failed_i);
          check_field("finished", want.finished, finished_i);
          check_field("trim_applied", want.applied, trim_applied_i);
          check_field("trimmed_fast", want.fast, trimmed_fast_i);
          check_field("trimmed_hz", want.hz, trimmed_hz_i);
        end
      end
      if (in_valid_i && in_ready_i) begin
        status_q.push_back(step_trim(req_e'(req_type_i), core_cycles_i));
      end
      pending_o = status_q.size();
    end
  end

endmodule

@@ verif/tb_top.sv @@
// Testbench top for the IRC auto-trim machine: clock, reset, request stimulus and verdict.
module tb_top
  import irc_atm_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  logic                clk_i         = 1'b0;
  logic                rst_ni        = 1'b0;
  logic                cfg_valid_i   = 1'b0;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i   = '0;
  logic [CfgDataW-1:0] cfg_data_i    = '0;
  logic                in_valid_i    = 1'b0;
  logic                in_ready_o;
  logic [1:0]          req_type_i    = '0;
  logic [CyclesW-1:0]  core_cycles_i = '0;
  logic                out_valid_o;
  logic                out_ready_i   = 1'b0;
  logic                busy_res_o;
  logic                failed_o;
  logic                finished_o;
  logic                trim_applied_o;
  logic                trimmed_fast_o;
  logic [HzW-1:0]      trimmed_hz_o;

  int unsigned errors;
  int unsigned pending;
  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned n_items        = 0;

  // what was last written, used to size advance requests
  logic [BusHzW-1:0]  sh_bus  = '0;
  logic [CoreHzW-1:0] sh_core = '0;
  logic [CmpW-1:0]    sh_cmp  = '0;
  logic               sh_fast = 1'b0;

  irc_auto_trim_machine_unit dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .req_type_i     (req_type_i),
    .core_cycles_i  (core_cycles_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .busy_res_o     (busy_res_o),
    .failed_o       (failed_o),
    .finished_o     (finished_o),
    .trim_applied_o (trim_applied_o),
    .trimmed_fast_o (trimmed_fast_o),
    .trimmed_hz_o   (trimmed_hz_o)
  );

  irc_trim_checker chk (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_i    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_ready_i     (in_ready_o),
    .req_type_i     (req_type_i),
    .core_cycles_i  (core_cycles_i),
    .out_valid_i    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .busy_res_i     (busy_res_o),
    .failed_i       (failed_o),
    .finished_i     (finished_o),
    .trim_applied_i (trim_applied_o),
    .trimmed_fast_i (trimmed_fast_o),
    .trimmed_hz_i   (trimmed_hz_o),
    .errors_o       (errors),
    .pending_o      (pending)
  );

  always #5 clk_i = ~clk_i;

  always @(negedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
  end

  initial begin
    #10ms;
    $display("== FAIL ==");
    $finish;
  end

  // leaves cfg_valid_i high; the caller lowers it after the last write
  task automatic write_reg(cfg_idx_e idx, logic [CfgDataW-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
  endtask

  task automatic set_config(logic [BusHzW-1:0] bus, logic [CoreHzW-1:0] core,
                            logic [CmpW-1:0] cmp, logic fast, logic iref,
                            logic [1:0] mode, logic ext, bit junk);
    logic [CfgDataW-1:0] hi;
    hi = junk ? CfgDataW'($urandom) : '0;
    write_reg(CFG_BUS_HZ, {hi[CfgDataW-1:BusHzW], bus});
    write_reg(CFG_CORE_HZ, core);
    write_reg(CFG_COMPARE, {hi[CfgDataW-1:CmpW], cmp});
    write_reg(CFG_FAST_SEL, {hi[CfgDataW-1:1], fast});
    write_reg(CFG_INT_REF, {hi[CfgDataW-1:1], iref});
    write_reg(CFG_SRC_MODE, {hi[CfgDataW-1:2], mode});
    write_reg(CFG_EXT_REF, {hi[CfgDataW-1:1], ext});
    if (junk) begin
      write_reg(CFG_UNUSED, hi);
    end
    cfg_valid_i <= 1'b0;
    sh_bus  = bus;
    sh_core = core;
    sh_cmp  = cmp;
    sh_fast = fast;
  endtask

  task automatic send_req(req_e req, logic [CyclesW-1:0] cyc);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i    <= 1'b1;
    req_type_i    <= req;
    core_cycles_i <= cyc;
    do @(posedge clk_i); while (!in_ready_o);
    @(negedge clk_i);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    do @(negedge clk_i); while (pending != 0);
  endtask

  // core cycles to spend a fraction of the countdown, or now and then anything
  function automatic logic [CyclesW-1:0] pick_cycles();
    logic [63:0] need;
    if (sh_bus == 0 || sh_core == 0 || $urandom_range(19) == 0) begin
      return $urandom;
    end
    need = 64'(sh_cmp == 0 ? 1 : sh_cmp) * (sh_fast ? 64'd4 : 64'd9) * 64'(sh_core) /
           64'(sh_bus);
    need = need / $urandom_range(1, 5) * $urandom_range(50, 150) / 100 + 1;
    return (need > 64'hFFFF_FFFF) ? '1 : CyclesW'(need);
  endfunction

  task automatic random_config();
    int unsigned        kind;
    int unsigned        ratio;
    logic [BusHzW-1:0]  bus;
    logic [CoreHzW-1:0] core;
    logic [CmpW-1:0]    cmp;
    logic [1:0]         mode;
    logic               fast;
    logic               iref;
    logic               ext;
    kind = $urandom_range(9);
    bus  = BusHzW'($urandom_range(BusMinHz, BusMaxHz));
    if ($urandom_range(4) == 0) begin
      bus = $urandom_range(1) ? BusMinHz : BusMaxHz;
    end
    core = CoreHzW'($urandom_range(bus, 200_000_000));
    mode = 2'($urandom_range(2));
    if (mode != 0) begin
      mode++;
    end
    iref = 1'b0;
    ext  = 1'b1;
    fast = (kind >= 4);
    if (fast) begin
      ratio = $urandom_range((bus + FastMaxHz - 1) / FastMaxHz, bus / FastMinHz);
      cmp   = CmpW'(ratio * FastFactor);
    end else begin
      ratio = $urandom_range((bus + SlowMaxHz - 1) / SlowMaxHz, bus / SlowMinHz);
      cmp   = CmpW'(ratio * SlowFactor);
    end
    case ($urandom_range(15))
      0: cmp++;
      1: iref = 1'b1;
      2: ext = 1'b0;
      3: mode = SrcModeInvalid;
      default: ;
    endcase
    if (kind >= 7) begin
      case ($urandom_range(3))
        0: bus = '0;
        1: bus = '1;
        2: bus = BusHzW'(100_000_000);
        default: bus = BusHzW'($urandom);
      endcase
      case ($urandom_range(2))
        0: core = '0;
        1: core = '1;
        default: core = CoreHzW'($urandom_range(1, 200_000_000));
      endcase
      case ($urandom_range(3))
        0: cmp = '0;
        1: cmp = '1;
        2: cmp = CmpW'(SlowFactor);
        default: cmp = CmpW'($urandom);
      endcase
      fast = 1'($urandom_range(1));
      iref = 1'($urandom_range(1));
      mode = 2'($urandom_range(3));
      ext  = 1'($urandom_range(1));
    end
    set_config(bus, core, cmp, fast, iref, mode, ext, kind >= 7);
  endtask

  task automatic run_trim_seq();
    int unsigned r;
    send_req(REQ_START, $urandom);
    n_items++;
    repeat ($urandom_range(1, 8)) begin
      r = $urandom_range(99);
      if (r < 4) begin
        send_req(REQ_ABORT, $urandom);
      end else if (r < 7) begin
        send_req(REQ_START, $urandom);
      end else begin
        send_req(REQ_ADVANCE, pick_cycles());
      end
      n_items++;
    end
  endtask

  initial begin
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // requests that change nothing while idle
    send_req(REQ_NONE, '1);
    send_req(REQ_ADVANCE, '0);
    send_req(REQ_ABORT, '0);

    // slow trim to completion: 12 MHz / (6720 / 21) = 37500 Hz
    drain();
    set_config(27'd12_000_000, 28'd48_000_000, 16'd6720, 1'b0, 1'b0, 2'd0, 1'b1, 1'b0);
    send_req(REQ_START, '0);
    send_req(REQ_ADVANCE, '0);
    send_req(REQ_ADVANCE, 32'd100_000);
    send_req(REQ_ADVANCE, '1);

    // fast trim, destination switched to slow before completion
    drain();
    set_config(27'd12_000_000, 28'd48_000_000, 16'd8064, 1'b1, 1'b0, 2'd2, 1'b1, 1'b0);
    send_req(REQ_START, '0);
    send_req(REQ_ADVANCE, 32'd1000);
    drain();
    write_reg(CFG_FAST_SEL, '0);
    cfg_valid_i <= 1'b0;
    sh_fast = 1'b0;
    send_req(REQ_ADVANCE, '1);

    // saturated target, restart while running, invalid trim fails
    drain();
    set_config('1, '1, CmpW'(SlowFactor), 1'b0, 1'b0, 2'd3, 1'b1, 1'b0);
    send_req(REQ_START, '0);
    send_req(REQ_START, '1);
    send_req(REQ_ADVANCE, '1);

    // stopped clocks, largest compare value, abort of a running trim
    drain();
    set_config('0, '0, '1, 1'b1, 1'b1, SrcModeInvalid, 1'b0, 1'b1);
    send_req(REQ_START, '0);
    send_req(REQ_ADVANCE, '1);
    send_req(REQ_ABORT, '0);
    send_req(REQ_START, '0);
    send_req(REQ_ADVANCE, '0);
    send_req(REQ_ABORT, '1);

    for (int phase = 0; n_items < 800; phase++) begin
      case (phase % 4)
        0: begin
          send_idle_pct  = 0;
          recv_stall_pct = 0;
        end
        1: begin
          send_idle_pct  = 79;
          recv_stall_pct = 0;
        end
        2: begin
          send_idle_pct  = 0;
          recv_stall_pct = 79;
        end
        default: begin
          send_idle_pct  = 11;
          recv_stall_pct = 11;
        end
      endcase
      drain();
      random_config();
      repeat ($urandom_range(3, 8)) begin
        if ($urandom_range(99) < 85) begin
          run_trim_seq();
        end else begin
          send_req(req_e'($urandom_range(3)),
                   $urandom_range(1) ? $urandom : $urandom_range(1000));
          n_items++;
        end
      end
    end

    drain();
    repeat (100) @(negedge clk_i);
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
sv/irc_atm_pkg.sv
sv/irc_auto_trim_machine_unit.sv
verif/irc_trim_checker.sv
verif/tb_top.sv
